### rtl/tia_pkg.sv
// Shared types and codes for the typed integer ALU.
`default_nettype none
package tia_pkg;
	localparam int DataWidth = 32;
	localparam int ShiftBits = $clog2(DataWidth);
	localparam int NumCells = DataWidth;

	typedef enum logic [4:0] {
		OP_MUL = 5'd0, OP_DIV = 5'd1, OP_REM = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
		OP_LNOT = 5'd5, OP_BNOT = 5'd6, OP_SHL = 5'd7, OP_SHR = 5'd8, OP_LT = 5'd9,
		OP_LE = 5'd10, OP_GT = 5'd11, OP_GE = 5'd12, OP_EQ = 5'd13, OP_NE = 5'd14,
		OP_AND = 5'd15, OP_XOR = 5'd16, OP_OR = 5'd17, OP_LAND = 5'd18,
		OP_SCAND = 5'd19, OP_LOR = 5'd20, OP_SCOR = 5'd21
	} op_t;

	localparam logic [1:0] KIND_NUM = 2'd0;
	localparam logic [1:0] KIND_BOOL = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_TYPE = 2'd1;
	localparam logic [1:0] ERR_DIV0 = 2'd2;
	localparam logic [1:0] ERR_NIMP = 2'd3;

	// Everything one divider cell hands to its neighbor.
	typedef struct packed {
		logic                 valid;
		logic                 is_div;
		logic                 q_neg;
		logic                 r_neg;
		logic [DataWidth-1:0] rem;
		logic [DataWidth-1:0] num;
		logic [DataWidth-1:0] den;
		logic [1:0]           kind;
		logic [DataWidth-1:0] value;
		logic [1:0]           err;
	} cell_t;
endpackage
`default_nettype wire

### rtl/tia_front.sv
// Type check and every operation except division and remainder; prepares the divider chain.
`default_nettype none
module tia_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [4:0]          mode,
	input  wire logic [1:0]          left_kind,
	input  wire logic [31:0]         left_value,
	input  wire logic [1:0]          right_kind,
	input  wire logic [31:0]         right_value,
	output tia_pkg::cell_t           cell_out
);
	import tia_pkg::*;

	logic [DataWidth-1:0] a, b, mag_a, mag_b, val;
	logic [1:0] lk, rk, kind, err;
	logic nums, bools, lt, is_dv, is_mul;
	logic [ShiftBits-1:0] cnt;
	logic [DataWidth-1:0] prod_s1;
	logic mul_s1;
	cell_t c_s1;

	always_comb begin
		a = DataWidth'($signed(left_value));
		b = DataWidth'($signed(right_value));
		lk = (left_kind == 2'd3) ? KIND_NONE : left_kind;
		rk = (right_kind == 2'd3) ? KIND_NONE : right_kind;
		nums = (lk == KIND_NUM) && (rk == KIND_NUM);
		bools = (lk == KIND_BOOL) && (rk == KIND_BOOL);
		cnt = b[ShiftBits-1:0];
		lt = $signed(a) < $signed(b);
		mag_a = a[DataWidth-1] ? -a : a;
		mag_b = b[DataWidth-1] ? -b : b;
		kind = KIND_NUM;
		val = '0;
		err = ERR_NONE;
		is_dv = 1'b0;
		is_mul = 1'b0;
		unique case (mode)
			OP_MUL: is_mul = 1'b1;
			OP_DIV, OP_REM: begin
				if (b == '0) err = ERR_DIV0;
				else is_dv = 1'b1;
			end
			OP_ADD: val = a + b;
			OP_SUB: val = a - b;
			OP_LNOT: begin
				if (rk == KIND_NONE) err = ERR_TYPE;
				else begin kind = KIND_BOOL; val = DataWidth'(b == '0); end
			end
			OP_BNOT: begin
				if (rk != KIND_NUM) err = ERR_TYPE;
				else val = ~b;
			end
			OP_SHL: val = a << cnt;
			OP_SHR: val = $signed(a) >>> cnt;
			OP_LT: begin kind = KIND_BOOL; val = DataWidth'(lt); end
			OP_LE: begin kind = KIND_BOOL; val = DataWidth'(lt || a == b); end
			OP_GT: begin kind = KIND_BOOL; val = DataWidth'(!lt && a != b); end
			OP_GE: begin kind = KIND_BOOL; val = DataWidth'(!lt); end
			OP_EQ, OP_NE: begin
				if (lk != rk) err = ERR_TYPE;
				else if (lk == KIND_NONE) err = ERR_NIMP;
				else begin
					kind = KIND_BOOL;
					val = DataWidth'(((lk == KIND_NUM) ? (a == b)
						: ((a != '0) == (b != '0))) ^ (mode == OP_NE));
				end
			end
			OP_AND: val = a & b;
			OP_XOR: val = a ^ b;
			OP_OR: val = a | b;
			OP_LAND, OP_LOR: begin
				if (!bools) err = ERR_TYPE;
				else begin
					kind = KIND_BOOL;
					val = DataWidth'((mode == OP_LAND) ? (a != '0 && b != '0)
						: (a != '0 || b != '0));
				end
			end
			OP_SCAND: begin
				if (lk != KIND_BOOL) err = ERR_TYPE;
				else if (a == '0) kind = KIND_BOOL;
				else kind = KIND_NONE;
			end
			OP_SCOR: begin
				if (lk != KIND_BOOL) err = ERR_TYPE;
				else if (a != '0) begin kind = KIND_BOOL; val = DataWidth'(1); end
				else kind = KIND_NONE;
			end
			default: err = ERR_NIMP;
		endcase
		// Arithmetic, shift, binary bitwise and ordering operations need two numbers.
		if (((mode <= OP_SUB) || (mode >= OP_SHL && mode <= OP_GE)
				|| (mode >= OP_AND && mode <= OP_OR)) && !nums) begin
			err = ERR_TYPE;
			is_dv = 1'b0;
			is_mul = 1'b0;
		end
		if (err != ERR_NONE) begin
			kind = KIND_NONE;
			val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
			prod_s1 <= '0;
			mul_s1 <= 1'b0;
		end else if (en) begin
			c_s1.valid <= in_valid;
			c_s1.is_div <= is_dv && (mode == OP_DIV);
			c_s1.q_neg <= is_dv && (a[DataWidth-1] ^ b[DataWidth-1]);
			c_s1.r_neg <= is_dv && a[DataWidth-1];
			c_s1.rem <= '0;
			c_s1.num <= mag_a;
			c_s1.den <= is_dv ? mag_b : '0;
			c_s1.kind <= kind;
			c_s1.value <= val;
			c_s1.err <= err;
			prod_s1 <= a * b;
			mul_s1 <= is_mul;
		end
	end

	// A multiply result rides in the value field through the chain.
	always_comb begin
		cell_out = c_s1;
		if (mul_s1) cell_out.value = prod_s1;
	end
endmodule
`default_nettype wire

### rtl/tia_cell.sv
// One restoring-division cell: retires one quotient bit per stage.
`default_nettype none
module tia_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  tia_pkg::cell_t      cell_in,
	output tia_pkg::cell_t      cell_out
);
	import tia_pkg::*;

	logic [DataWidth:0] trial;
	logic [DataWidth-1:0] shifted;
	cell_t nxt;

	always_comb begin
		nxt = cell_in;
		shifted = {cell_in.rem[DataWidth-2:0], cell_in.num[DataWidth-1]};
		trial = {1'b0, shifted} - {1'b0, cell_in.den};
		// A zero divisor marks an item that only passes through.
		if (cell_in.den != '0) begin
			if (!trial[DataWidth]) begin
				nxt.rem = trial[DataWidth-1:0];
				nxt.num = {cell_in.num[DataWidth-2:0], 1'b1};
			end else begin
				nxt.rem = shifted;
				nxt.num = {cell_in.num[DataWidth-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out <= '0;
		end else if (en) begin
			cell_out <= nxt;
		end
	end
endmodule
`default_nettype wire

### rtl/typed_integer_alu.sv
// Top level of the typed integer ALU.
`default_nettype none
// Fully pipelined typed ALU: one item may enter every cycle while the output
// is not stalled, and its result can be taken once it has passed the input
// stage and the divider, a chain of one cell per quotient bit; every
// operation travels the same chain so results keep their order. A stalled
// output freezes the whole pipeline, and s_tready is high whenever the last
// stage is empty or being taken.
module typed_integer_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// mode[4:0], left_kind[6:5], left_value[38:7], right_kind[40:39],
	// right_value[72:41], zero fill
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// result_kind[1:0], result_value[33:2], error_code[35:34], zero fill
	output logic [39:0]      m_tdata
);
	import tia_pkg::*;

	cell_t chain [NumCells+1];
	logic en;
	logic [DataWidth-1:0] q;
	cell_t last;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	tia_front u_front (
		.clk, .arst_n, .en,
		.in_valid(s_tvalid),
		.mode(s_tdata[4:0]),
		.left_kind(s_tdata[6:5]),
		.left_value(s_tdata[38:7]),
		.right_kind(s_tdata[40:39]),
		.right_value(s_tdata[72:41]),
		.cell_out(chain[0])
	);

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		tia_cell u_cell (.clk, .arst_n, .en, .cell_in(chain[i]), .cell_out(chain[i+1]));
	end

	assign last = chain[NumCells];

	always_comb begin
		q = last.value;
		if (last.den != '0) begin
			if (last.is_div) q = last.q_neg ? -last.num : last.num;
			else q = last.r_neg ? -last.rem : last.rem;
		end
	end

	assign m_tvalid = last.valid;
	assign m_tdata = {4'd0, last.err, 32'($signed(q)), last.kind};
endmodule
`default_nettype wire

### rtl/tia_checker.sv
// Port-level checker for the typed integer ALU, bound to the top level.
`default_nettype none
module tia_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);
	import tia_pkg::*;

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == KIND_NONE |-> m_tdata[33:2] == '0)
		else $error("no-value result with data");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35:34] != ERR_NONE |-> m_tdata[1:0] == KIND_NONE)
		else $error("error with a value");
endmodule

bind typed_integer_alu tia_checker u_tia_checker (.*);
`default_nettype wire
